/* sv/debounced_step_quadrature_counter_defines.svh */
// Assertion macros shared by the counter block.
`ifndef DEBOUNCED_STEP_QUADRATURE_COUNTER_DEFINES_SVH
`define DEBOUNCED_STEP_QUADRATURE_COUNTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define DSQC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsqc same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define DSQC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsqc next-cycle check failed");

`endif

/* sv/dsqc_pkg.sv */
package dsqc_pkg;

    // Debounce history
    localparam int unsigned HIST_W = 13;
    localparam logic [HIST_W-1:0] HIST_FIRE = 13'h1000;
    localparam logic [HIST_W-1:0] HIST_RESET = '0;

    // Buttons that have an input bit
    localparam int unsigned RAW_BUTTONS = 3;

    // Step codes
    localparam logic [2:0] STEP_ONE  = 3'd1;
    localparam logic [2:0] STEP_TWO  = 3'd2;
    localparam logic [2:0] STEP_FOUR = 3'd4;

    // Encoder phase codes
    localparam logic [1:0] PHASE_IDLE = 2'b00;
    localparam logic [1:0] PHASE_UP   = 2'b01;
    localparam logic [1:0] PHASE_DOWN = 2'b10;

    localparam int unsigned COUNT_W = 10;

    typedef struct packed {
        logic [2:0] buttons_n;
        logic [1:0] enc_phase;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [2:0]         step;
    } out_item_t;

    function automatic logic [2:0] step_code(input int unsigned idx);
        logic [2:0] code;
        code = STEP_ONE;
        case (idx)
            0:       code = STEP_ONE;
            1:       code = STEP_TWO;
            2:       code = STEP_FOUR;
            default: code = STEP_ONE;
        endcase
        return code;
    endfunction

endpackage

/* sv/dsqc_debounce.sv */
module dsqc_debounce #(
    parameter int unsigned NUM_BUTTONS = 3
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [2:0] buttons_n,
    output logic [2:0] step_next
);

    localparam int unsigned USED =
        (NUM_BUTTONS < dsqc_pkg::RAW_BUTTONS) ? NUM_BUTTONS : dsqc_pkg::RAW_BUTTONS;

    logic [dsqc_pkg::HIST_W-1:0] hist_reg  [NUM_BUTTONS];
    logic [dsqc_pkg::HIST_W-1:0] hist_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]      fire;
    logic [2:0]                  step_reg;

    genvar g;
    generate
        for (g = 0; g < NUM_BUTTONS; g++)
        begin : g_btn
            logic released;
            if (g < dsqc_pkg::RAW_BUTTONS)
            begin : g_raw
                assign released = buttons_n[g];
            end
            else
            begin : g_none
                // No input bit: the button reads as pressed.
                assign released = 1'b0;
            end

            assign hist_next[g] = {hist_reg[g][dsqc_pkg::HIST_W-2:0], released};
            assign fire[g]      = (hist_next[g] == dsqc_pkg::HIST_FIRE);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    hist_reg[g] <= dsqc_pkg::HIST_RESET;
                else if (advance)
                    hist_reg[g] <= hist_next[g];
            end
        end
    endgenerate

    // Higher button wins: scan upward, last hit holds.
    always_comb
    begin
        step_next = step_reg;
        for (int unsigned i = 0; i < USED; i++)
        begin
            if (fire[i])
                step_next = dsqc_pkg::step_code(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= dsqc_pkg::STEP_ONE;
        else if (advance)
            step_reg <= step_next;
    end

endmodule

/* sv/dsqc_count.sv */
module dsqc_count #(
    parameter int unsigned COUNT_LIMIT = 1023
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [1:0]          enc_phase,
    input  logic [2:0]          step_next,
    output dsqc_pkg::out_item_t result
);

    localparam int unsigned CNT_W = $clog2(COUNT_LIMIT + 1);
    localparam int unsigned SUM_W = CNT_W + 2;
    localparam logic signed [SUM_W-1:0] LIMIT_S = SUM_W'(COUNT_LIMIT);

    logic [CNT_W-1:0]        pos_reg;
    logic [CNT_W-1:0]        pos_next;
    logic [1:0]              phase_reg;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] wrapped;
    logic [CNT_W+dsqc_pkg::COUNT_W-1:0] pos_wide;

    assign base  = signed'({2'b00, pos_reg});
    assign delta = signed'({{(SUM_W-3){1'b0}}, step_next});

    always_comb
    begin
        sum = base;
        if (phase_reg == dsqc_pkg::PHASE_IDLE)
        begin
            if (enc_phase == dsqc_pkg::PHASE_UP)
                sum = base + delta;
            else if (enc_phase == dsqc_pkg::PHASE_DOWN)
                sum = base - delta;
        end

        // Wrap: drop the limit once above it, jump to the limit below zero.
        wrapped = sum;
        if (sum > LIMIT_S)
            wrapped = sum - LIMIT_S;
        else if (sum < 0)
            wrapped = LIMIT_S;

        pos_next = wrapped[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= dsqc_pkg::PHASE_IDLE;
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            phase_reg <= enc_phase;
        end
    end

    assign pos_wide     = {{dsqc_pkg::COUNT_W{1'b0}}, pos_next};
    assign result.count = pos_wide[dsqc_pkg::COUNT_W-1:0];
    assign result.step  = step_next;

endmodule

/* sv/debounced_step_quadrature_counter.sv */
// Each accepted sample passes from the input register into the result register at out_data.
// Throughput: one item per cycle unless out_ready stalls; the input and result registers
// form a two-stage pipe, and the debounce, step and count state all update in the single pass
// between them. Reset (rst_n low, asynchronous): both stages empty, histories cleared,
// step 1, count 0, last phase 00.
`include "debounced_step_quadrature_counter_defines.svh"

module debounced_step_quadrature_counter #(
    parameter int unsigned NUM_BUTTONS = 3,
    parameter int unsigned COUNT_LIMIT = 1023
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dsqc_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dsqc_pkg::out_item_t out_data
);

    // Input stage: one tick sample waiting to be worked.
    logic                in_valid_reg;
    logic                in_valid_next;
    dsqc_pkg::in_item_t  in_reg;

    // Result stage: holds the finished result until the downstream transfer.
    logic                out_valid_reg;
    logic                out_valid_next;
    dsqc_pkg::out_item_t out_reg;

    logic                advance;
    logic [2:0]          step_next;
    dsqc_pkg::out_item_t result;
    logic                step_legal;

    // Advance the sample into the result stage when that stage is free or draining.
    // All debounce, step, count and result state commits on this same condition, so a stalled result
    // never lets the counter run ahead.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign in_valid_next  = in_ready ? in_valid : in_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on transfer or advance, otherwise hold.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_data;
        if (advance)
            out_reg <= result;
    end

    // Debounce bank and step select.
    dsqc_debounce #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_debounce (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .buttons_n (in_reg.buttons_n),
        .step_next (step_next)
    );

    // Phase decode, count update and wrap.
    dsqc_count #(
        .COUNT_LIMIT (COUNT_LIMIT)
    ) u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .enc_phase (in_reg.enc_phase),
        .step_next (step_next),
        .result    (result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign step_legal = (out_reg.step == dsqc_pkg::STEP_ONE)
                     || (out_reg.step == dsqc_pkg::STEP_TWO)
                     || (out_reg.step == dsqc_pkg::STEP_FOUR);

    // A sample that moves on always yields a result in the next cycle.
    `DSQC_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, out_valid_reg)
    // A sample that cannot move stays in the input stage.
    `DSQC_ASSERT_NEXT(a_hold_input, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    // The reported step is always one of the three legal sizes.
    `DSQC_ASSERT_SAME(a_step_legal, clk, rst_n, out_valid_reg, step_legal)
    // The reported count never exceeds the limit.
    `DSQC_ASSERT_SAME(a_count_range, clk, rst_n, out_valid_reg, 32'(out_reg.count) <= COUNT_LIMIT)

endmodule
